### rtl/vector3_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vector arithmetic unit
// Clocked on clk; the same-cycle implication form is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define V3AU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector unit check failed");

// next-cycle implication, live during reset
`define V3AU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vector unit check failed");

`endif

### rtl/v3au_pkg.sv
// ----------------------------------------------------------------------------
// v3au_pkg
// Widths, codes, pipeline records and saturation helper of the vector unit.
// ----------------------------------------------------------------------------
package v3au_pkg;

  localparam int W      = 32;            // component width
  localparam int FRAC   = 16;            // fraction bits
  localparam int OPW    = W + 2;         // multiplier operand width
  localparam int PW     = 2 * OPW;       // product width
  localparam int SAT_W  = PW + 2;        // room for a sum of three products
  localparam int NUM_W  = W + FRAC;      // dividend magnitude width
  localparam int DEN_W  = W + 1;         // divisor magnitude width
  localparam int ROOT_W = W + 1;         // square root width
  localparam int RAD_W  = 2 * ROOT_W;    // radicand width
  localparam int REM_W  = ROOT_W + 4;    // square root remainder width

  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [1:0] REG_ACTIVE_DIMS = 2'd0;
  localparam logic [1:0] REG_ZERO_TOL    = 2'd1;

  typedef enum logic [3:0] {
    F_ADD     = 4'd0,
    F_SUB     = 4'd1,
    F_SCALE   = 4'd2,
    F_DIV     = 4'd3,
    F_NEG     = 4'd4,
    F_DOT     = 4'd5,
    F_CROSS   = 4'd6,
    F_LENGTH  = 4'd7,
    F_DIST    = 4'd8,
    F_NORM    = 4'd9,
    F_IS_ZERO = 4'd10,
    F_EQUAL   = 4'd11
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIVZ  = 2'd1,
    ST_CROSS = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic [W-1:0]         simple;
    logic                 simple_sat;
    logic                 near_zero;
    logic                 same;
    logic                 a_neg;
    logic [NUM_W-1:0]     num;
  } lane_t;

  typedef struct packed {
    func_t                  func;
    status_t                status;
    logic                   satf;
    logic                   truth;
    logic [2:0][W-1:0]      r;
    logic [W-1:0]           sc;
    logic [2:0]             neg;
    logic [2:0][NUM_W-1:0]  num;
    logic [DEN_W-1:0]       den;
  } carry_t;

  // clamp to the signed component range; bit W is the clamp flag
  function automatic logic [W:0] sat_w(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = {{(SAT_W-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return {1'b1, SMAX};
    else if (v < lo) return {1'b1, SMIN};
    else return {1'b0, v[W-1:0]};
  endfunction

endpackage

### rtl/v3au_lane.sv
// ----------------------------------------------------------------------------
// v3au_lane
// One component lane: operand select, two products, the simple arithmetic.
// ----------------------------------------------------------------------------
module v3au_lane import v3au_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  func_t               func,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] aj,
  input  logic signed [W-1:0] bk,
  input  logic signed [W-1:0] ak,
  input  logic signed [W-1:0] bj,
  input  logic signed [W-1:0] s,
  input  logic [W-2:0]        tol,
  output lane_t               q
);

  logic signed [W:0]     d;
  logic signed [W:0]     simple_ext;
  logic signed [OPW-1:0] x1, y1, x2, y2;
  logic [W-1:0]          abs_a;

  always_comb begin
    d          = {a[W-1], a} - {b[W-1], b};
    x1         = '0;
    y1         = '0;
    x2         = '0;
    y2         = '0;
    simple_ext = '0;
    case (func)
      F_ADD:   simple_ext = {a[W-1], a} + {b[W-1], b};
      F_SUB:   simple_ext = d;
      F_NEG:   simple_ext = -{a[W-1], a};
      F_SCALE: begin
        x1 = {{2{a[W-1]}}, a};
        y1 = {{2{s[W-1]}}, s};
      end
      F_DOT: begin
        x1 = {{2{a[W-1]}}, a};
        y1 = {{2{b[W-1]}}, b};
      end
      F_CROSS: begin
        x1 = {{2{aj[W-1]}}, aj};
        y1 = {{2{bk[W-1]}}, bk};
        x2 = {{2{ak[W-1]}}, ak};
        y2 = {{2{bj[W-1]}}, bj};
      end
      F_LENGTH, F_NORM: begin
        x1 = {{2{a[W-1]}}, a};
        y1 = {{2{a[W-1]}}, a};
      end
      F_DIST: begin
        x1 = {d[W], d};
        y1 = {d[W], d};
      end
      default: ;
    endcase
    abs_a = a[W-1] ? (W'(0) - a) : a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.p1         <= x1 * y1;
      q.p2         <= x2 * y2;
      // clamp on overflow; bit W carries the sign of the true result
      q.simple     <= (simple_ext[W] != simple_ext[W-1]) ? (simple_ext[W] ? SMIN : SMAX)
                                                         : simple_ext[W-1:0];
      q.simple_sat <= simple_ext[W] != simple_ext[W-1];
      q.near_zero  <= abs_a <= {1'b0, tol};
      q.same       <= a == b;
      q.a_neg      <= a[W-1];
      q.num        <= {abs_a, {FRAC{1'b0}}};
    end
  end

endmodule

### rtl/v3au_merge.sv
// ----------------------------------------------------------------------------
// v3au_merge
// Combine the lanes: sums, cross differences, tests and divider setup.
// ----------------------------------------------------------------------------
module v3au_merge import v3au_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  lane_t [2:0]         ln,
  input  func_t               func,
  input  logic signed [W-1:0] s,
  input  logic                cross_ok,
  output carry_t              q,
  output logic [RAD_W-1:0]    rad
);

  carry_t                  c;
  logic signed [SAT_W-1:0] sum;
  logic [W:0]              dot_r;
  logic [2:0][W:0]         sc_r;
  logic [2:0][W:0]         cr_r;
  logic [DEN_W-1:0]        sx;

  always_comb begin
    sum = SAT_W'($signed(ln[0].p1)) + SAT_W'($signed(ln[1].p1))
        + SAT_W'($signed(ln[2].p1));
    dot_r = sat_w(sum >>> FRAC);
    for (int i = 0; i < 3; i++) begin
      sc_r[i] = sat_w(SAT_W'($signed(ln[i].p1)) >>> FRAC);
      cr_r[i] = sat_w((SAT_W'($signed(ln[i].p1)) - SAT_W'($signed(ln[i].p2))) >>> FRAC);
    end
    sx       = {s[W-1], s};
    c        = '0;
    c.func   = func;
    c.status = ST_OK;
    for (int i = 0; i < 3; i++) c.num[i] = ln[i].num;
    case (func)
      F_ADD, F_SUB, F_NEG: begin
        for (int i = 0; i < 3; i++) c.r[i] = ln[i].simple;
        c.satf = ln[0].simple_sat | ln[1].simple_sat | ln[2].simple_sat;
      end
      F_SCALE: begin
        for (int i = 0; i < 3; i++) c.r[i] = sc_r[i][W-1:0];
        c.satf = sc_r[0][W] | sc_r[1][W] | sc_r[2][W];
      end
      F_DIV: begin
        if (s == '0) c.status = ST_DIVZ;
        c.den = s[W-1] ? (DEN_W'(0) - sx) : sx;
        for (int i = 0; i < 3; i++) c.neg[i] = ln[i].a_neg ^ s[W-1];
      end
      F_DOT: begin
        c.sc   = dot_r[W-1:0];
        c.satf = dot_r[W];
      end
      F_CROSS: begin
        if (!cross_ok) begin
          c.status = ST_CROSS;
        end else begin
          for (int i = 0; i < 3; i++) c.r[i] = cr_r[i][W-1:0];
          c.satf = cr_r[0][W] | cr_r[1][W] | cr_r[2][W];
        end
      end
      F_NORM: begin
        for (int i = 0; i < 3; i++) c.neg[i] = ln[i].a_neg;
      end
      F_IS_ZERO: c.truth = ln[0].near_zero & ln[1].near_zero & ln[2].near_zero;
      F_EQUAL:   c.truth = ln[0].same & ln[1].same & ln[2].same;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q   <= c;
      // squares are never negative, so the low bits are the whole sum
      rad <= sum[RAD_W-1:0];
    end
  end

endmodule

### rtl/v3au_sqrt.sv
// ----------------------------------------------------------------------------
// v3au_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v3au_sqrt import v3au_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  carry_t            c_in,
  input  logic [RAD_W-1:0]  rad_in,
  output carry_t            c_out,
  output logic [ROOT_W-1:0] root_out
);

  carry_t            cs [ROOT_W];
  logic [RAD_W-1:0]  rs [ROOT_W];
  logic [REM_W-1:0]  rm [ROOT_W];
  logic [ROOT_W-1:0] rt [ROOT_W];

  carry_t            c_p   [ROOT_W];
  logic [RAD_W-1:0]  rad_p [ROOT_W];
  logic [REM_W-1:0]  rem_sh[ROOT_W];
  logic [REM_W-1:0]  trial [ROOT_W];
  logic [ROOT_W-1:0] root_p[ROOT_W];

  always_comb begin
    for (int j = 0; j < ROOT_W; j++) begin
      if (j == 0) begin
        c_p[j]    = c_in;
        rad_p[j]  = rad_in;
        root_p[j] = '0;
        rem_sh[j] = REM_W'(rad_in[RAD_W-1 -: 2]);
      end else begin
        c_p[j]    = cs[j-1];
        rad_p[j]  = rs[j-1];
        root_p[j] = rt[j-1];
        rem_sh[j] = {rm[j-1][REM_W-3:0], rs[j-1][RAD_W-1 -: 2]};
      end
      trial[j] = REM_W'({root_p[j], 2'b01});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ROOT_W; j++) begin
        cs[j] <= c_p[j];
        rs[j] <= rad_p[j] << 2;
        if (rem_sh[j] >= trial[j]) begin
          rm[j] <= rem_sh[j] - trial[j];
          rt[j] <= {root_p[j][ROOT_W-2:0], 1'b1};
        end else begin
          rm[j] <= rem_sh[j];
          rt[j] <= {root_p[j][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign c_out    = cs[ROOT_W-1];
  assign root_out = rt[ROOT_W-1];

endmodule

### rtl/v3au_div.sv
// ----------------------------------------------------------------------------
// v3au_div
// Three-lane pipelined restoring divider on magnitudes, one quotient bit
// per stage, sharing one divisor.
// ----------------------------------------------------------------------------
module v3au_div import v3au_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  carry_t                c_in,
  output carry_t                c_out,
  output logic [2:0][NUM_W-1:0] q_out
);

  carry_t                  cs [NUM_W];
  logic [2:0][DEN_W-1:0]   rm [NUM_W];
  logic [2:0][NUM_W-1:0]   qs [NUM_W];

  carry_t                  c_p  [NUM_W];
  logic [2:0][DEN_W:0]     rsh  [NUM_W];
  logic [2:0]              ge   [NUM_W];
  logic [2:0][NUM_W-1:0]   q_p  [NUM_W];

  always_comb begin
    for (int j = 0; j < NUM_W; j++) begin
      c_p[j] = (j == 0) ? c_in : cs[j-1];
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          q_p[j][l] = '0;
          rsh[j][l] = (DEN_W+1)'(c_in.num[l][NUM_W-1]);
        end else begin
          q_p[j][l] = qs[j-1][l];
          rsh[j][l] = {rm[j-1][l], cs[j-1].num[l][NUM_W-1-j]};
        end
        ge[j][l] = rsh[j][l] >= {1'b0, c_p[j].den};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_W; j++) begin
        cs[j] <= c_p[j];
        for (int l = 0; l < 3; l++) begin
          rm[j][l] <= ge[j][l] ? DEN_W'(rsh[j][l] - {1'b0, c_p[j].den})
                               : DEN_W'(rsh[j][l]);
          qs[j][l] <= {q_p[j][l][NUM_W-2:0], ge[j][l]};
        end
      end
    end
  end

  assign c_out = cs[NUM_W-1];
  assign q_out = qs[NUM_W-1];

endmodule

### rtl/vector3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Q16.16 three-component vector ALU: add, sub, scale, divide, negate, dot,
// cross, length, distance, normalize, zero test and equality.
// ----------------------------------------------------------------------------
// Fully pipelined: one request enters per cycle unless the output stalls.
// Each result passes through 1 lane product stage, 1 merge stage, 33
// square root stages at one root bit each, 48 divider stages at one
// quotient bit each and 1 output register. Every function runs the same
// path, so results come out in order. While a result waits at the output,
// the whole pipeline holds and s_tready is low. Configuration writes are
// taken every cycle and apply to requests accepted afterwards.
module vector3_arithmetic_unit import v3au_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in (32 bits each)
  input  logic [223:0] s_tdata,
  // func[3:0]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_x, r_y, r_z, scalar_out (32 bits each), truth[128], zero pad
  output logic [135:0] m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [W-2:0] cfg_data
);

  `include "vector3_arithmetic_unit_defines.svh"

  localparam int LAT = 2 + ROOT_W + NUM_W;

  logic [1:0]   active_dims;
  logic [W-2:0] zero_tolerance;
  logic         adv;
  logic [LAT-1:0] vpipe;

  logic [1:0]          n;
  logic [2:0]          act;
  logic signed [W-1:0] a_in [3];
  logic signed [W-1:0] b_in [3];
  logic signed [W-1:0] a_m  [3];
  logic signed [W-1:0] b_m  [3];
  logic signed [W-1:0] s_in;
  func_t               f_in;

  lane_t [2:0]         ln;
  func_t               s1_func;
  logic signed [W-1:0] s1_s;
  logic                s1_cross_ok;

  carry_t              mg_c;
  logic [RAD_W-1:0]    mg_rad;
  carry_t              sq_c;
  logic [ROOT_W-1:0]   sq_root;
  carry_t              dv_in;
  carry_t              dv_c;
  logic [2:0][NUM_W-1:0] dv_q;

  carry_t              fin;
  logic [2:0][W-1:0]   r_out;
  logic [W-1:0]        sc_out;
  logic                truth_out;
  status_t             status_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_dims    <= 2'd3;
      zero_tolerance <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVE_DIMS: active_dims    <= cfg_data[1:0];
        REG_ZERO_TOL:    zero_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance every stage together; hold all while the output waits
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    n      = (active_dims == 2'd0) ? 2'd1 : active_dims;
    act[0] = 1'b1;
    act[1] = n >= 2'd2;
    act[2] = n == 2'd3;
    f_in   = func_t'(s_tuser);
    s_in   = s_tdata[7*W-1 -: W];
    for (int i = 0; i < 3; i++) begin
      a_in[i] = s_tdata[i*W +: W];
      b_in[i] = s_tdata[(i+3)*W +: W];
      a_m[i]  = act[i] ? a_in[i] : '0;
      b_m[i]  = act[i] ? b_in[i] : '0;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3au_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .func (f_in),
      .a    (a_m[i]),
      .b    (b_m[i]),
      .aj   (a_m[(i+1)%3]),
      .bk   (b_m[(i+2)%3]),
      .ak   (a_m[(i+2)%3]),
      .bj   (b_m[(i+1)%3]),
      .s    (s_in),
      .tol  (zero_tolerance),
      .q    (ln[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func     <= f_in;
      s1_s        <= s_in;
      s1_cross_ok <= n == 2'd3;
    end
  end

  v3au_merge u_merge (
    .clk      (clk),
    .en       (adv),
    .ln       (ln),
    .func     (s1_func),
    .s        (s1_s),
    .cross_ok (s1_cross_ok),
    .q        (mg_c),
    .rad      (mg_rad)
  );

  v3au_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .c_in     (mg_c),
    .rad_in   (mg_rad),
    .c_out    (sq_c),
    .root_out (sq_root)
  );

  // apply the root: scalar for length and distance, divisor for normalize
  always_comb begin
    dv_in = sq_c;
    case (sq_c.func)
      F_LENGTH, F_DIST: begin
        if (sq_root > ROOT_W'(SMAX)) begin
          dv_in.sc   = SMAX;
          dv_in.satf = 1'b1;
        end else begin
          dv_in.sc = sq_root[W-1:0];
        end
      end
      F_NORM: begin
        if (sq_root == '0) dv_in.status = ST_DIVZ;
        dv_in.den = DEN_W'(sq_root);
      end
      default: ;
    endcase
  end

  v3au_div u_div (
    .clk   (clk),
    .en    (adv),
    .c_in  (dv_in),
    .c_out (dv_c),
    .q_out (dv_q)
  );

  // sign and clamp the quotients, then fold saturation into status
  always_comb begin
    fin = dv_c;
    if ((dv_c.func == F_DIV || dv_c.func == F_NORM) && dv_c.status == ST_OK) begin
      for (int i = 0; i < 3; i++) begin
        if (!dv_c.neg[i]) begin
          if (dv_q[i] > NUM_W'(SMAX)) begin
            fin.r[i] = SMAX;
            fin.satf = 1'b1;
          end else begin
            fin.r[i] = dv_q[i][W-1:0];
          end
        end else begin
          if (dv_q[i] > NUM_W'(SMAX) + NUM_W'(1)) begin
            fin.r[i] = SMIN;
            fin.satf = 1'b1;
          end else begin
            fin.r[i] = W'(0) - dv_q[i][W-1:0];
          end
        end
      end
    end
    if (fin.satf && fin.status == ST_OK) fin.status = ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe    <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vpipe    <= {vpipe[LAT-2:0], s_tvalid};
      m_tvalid <= vpipe[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_out      <= fin.r;
      sc_out     <= fin.sc;
      truth_out  <= fin.truth;
      status_out <= fin.status;
    end
  end

  assign m_tdata = {7'b0, truth_out, sc_out, r_out[2], r_out[1], r_out[0]};
  assign m_tuser = status_out;

  `V3AU_ASSERT_IMP(a_divz_zero_vec, m_tvalid && status_out == ST_DIVZ, r_out == '0)
  `V3AU_ASSERT_IMP(a_cross_zero_vec, m_tvalid && status_out == ST_CROSS, r_out == '0)
  `V3AU_ASSERT_IMP(a_truth_ok, m_tvalid && truth_out, status_out == ST_OK && sc_out == '0)
  `V3AU_ASSERT_IMP(a_scalar_no_vec, m_tvalid && sc_out != '0, r_out == '0)
  `V3AU_ASSERT_NXT(a_reset_empty, rst, !m_tvalid && vpipe == '0)

endmodule

### test/vector3_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_tb
// Drives vector requests through the stream ports, predicts or looks up
// each result in fixed point, checks each in order. A short directed table
// leads, then random phases under several dimension and tolerance settings.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_tb;
  import v3au_pkg::*;

  typedef struct packed {
    logic [3:0]        func;
    logic [2:0][31:0]  a;
    logic [2:0][31:0]  b;
    logic [31:0]       s;
  } vec_req_t;

  typedef struct packed {
    logic [2:0][31:0]  r;
    logic [31:0]       sc;
    logic              truth;
    logic [1:0]        status;
  } vec_res_t;

  typedef struct packed {
    vec_req_t req;
    logic     fixed;
    vec_res_t res;
  } vec_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;
  logic [3:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [30:0]  cfg_data;

  // fixed expectation travelling with the current request
  logic         row_fixed;
  vec_res_t     row_res;

  logic [1:0]   dims_q;
  logic [30:0]  tol_q;
  vec_res_t     pending_results[$];
  vec_row_t     rows[$];
  int           errors;
  int           n_req;
  int           n_res;
  int           status_seen[4];
  int           gap_max;
  int           rx_max;
  int           idle_cycles;

  vector3_arithmetic_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [32:0] clamp32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) return {1'b1, SMAX};
    if (v < -70'sd2147483648) return {1'b1, SMIN};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [35:0] root_of(input logic [71:0] sum);
    logic [35:0] r;
    logic [35:0] c;
    logic [71:0] cc;
    r = '0;
    for (int bit_i = 35; bit_i >= 0; bit_i--) begin
      c = r | (36'd1 << bit_i);
      cc = {36'd0, c} * {36'd0, c};
      if (cc <= sum) r = c;
    end
    return r;
  endfunction

  function automatic logic [35:0] length_of(input logic signed [69:0] v0,
                                            input logic signed [69:0] v1,
                                            input logic signed [69:0] v2);
    logic [71:0] m0;
    logic [71:0] m1;
    logic [71:0] m2;
    m0 = (v0 < 0) ? -v0 : v0;
    m1 = (v1 < 0) ? -v1 : v1;
    m2 = (v2 < 0) ? -v2 : v2;
    return root_of(m0 * m0 + m1 * m1 + m2 * m2);
  endfunction

  function automatic vec_res_t compute_vec_result(input vec_req_t q);
    vec_res_t res;
    logic signed [69:0] av[3];
    logic signed [69:0] bv[3];
    logic signed [69:0] dv[3];
    logic signed [69:0] sv;
    logic signed [69:0] acc;
    logic [32:0] cl;
    logic [35:0] len;
    logic satf;
    int n;
    int j;
    int k;
    res = '0;
    satf = 1'b0;
    n = (dims_q == 0) ? 1 : dims_q;
    sv = $signed(q.s);
    for (int i = 0; i < 3; i++) begin
      if (i < n) begin
        av[i] = $signed(q.a[i]);
        bv[i] = $signed(q.b[i]);
      end else begin
        av[i] = 0;
        bv[i] = 0;
      end
      dv[i] = av[i] - bv[i];
    end
    case (q.func)
      F_ADD, F_SUB, F_SCALE, F_NEG: begin
        for (int i = 0; i < 3; i++) begin
          case (q.func)
            F_ADD:   acc = av[i] + bv[i];
            F_SUB:   acc = dv[i];
            F_SCALE: acc = (av[i] * sv) >>> 16;
            default: acc = -av[i];
          endcase
          cl = clamp32(acc);
          res.r[i] = cl[31:0];
          satf |= cl[32];
        end
      end
      F_DIV: begin
        if (sv == 0) res.status = ST_DIVZ;
        else begin
          for (int i = 0; i < 3; i++) begin
            cl = clamp32((av[i] * 70'sd65536) / sv);
            res.r[i] = cl[31:0];
            satf |= cl[32];
          end
        end
      end
      F_DOT: begin
        cl = clamp32((av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2]) >>> 16);
        res.sc = cl[31:0];
        satf = cl[32];
      end
      F_CROSS: begin
        if (n != 3) res.status = ST_CROSS;
        else begin
          for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            cl = clamp32((av[j] * bv[k] - av[k] * bv[j]) >>> 16);
            res.r[i] = cl[31:0];
            satf |= cl[32];
          end
        end
      end
      F_LENGTH, F_DIST: begin
        if (q.func == F_LENGTH) len = length_of(av[0], av[1], av[2]);
        else len = length_of(dv[0], dv[1], dv[2]);
        if (len > 36'd2147483647) begin
          satf = 1'b1;
          res.sc = SMAX;
        end else res.sc = len[31:0];
      end
      F_NORM: begin
        len = length_of(av[0], av[1], av[2]);
        if (len == 0) res.status = ST_DIVZ;
        else begin
          for (int i = 0; i < 3; i++) begin
            cl = clamp32((av[i] * 70'sd65536) / $signed({34'd0, len}));
            res.r[i] = cl[31:0];
            satf |= cl[32];
          end
        end
      end
      F_IS_ZERO: begin
        res.truth = 1'b1;
        for (int i = 0; i < 3; i++)
          if (((av[i] < 0) ? -av[i] : av[i]) > $signed({39'd0, tol_q})) res.truth = 1'b0;
      end
      F_EQUAL: res.truth = (av[0] == bv[0]) && (av[1] == bv[1]) && (av[2] == bv[2]);
      default: ;
    endcase
    if (satf && res.status == ST_OK) res.status = ST_SAT;
    return res;
  endfunction

  // queue an expected result on every accepted request
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      n_req++;
      if (row_fixed) pending_results = {pending_results, row_res};
      else pending_results = {pending_results,
                              compute_vec_result({s_tuser, s_tdata[95:0], s_tdata[191:96],
                                                  s_tdata[223:192]})};
    end
  end

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    vec_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_res++;
      status_seen[m_tuser]++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h/%h", $time, m_tdata,
                 m_tuser);
      end else begin
        e = pending_results.pop_front();
        check_field("r_x", e.r[0], m_tdata[31:0]);
        check_field("r_y", e.r[1], m_tdata[63:32]);
        check_field("r_z", e.r[2], m_tdata[95:64]);
        check_field("scalar_out", e.sc, m_tdata[127:96]);
        check_field("truth", {31'd0, e.truth}, {31'd0, m_tdata[128]});
        check_field("status", {30'd0, e.status}, {30'd0, m_tuser});
      end
    end
  end

  // abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= 20000) begin
      $display("*** FAILED ***");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // result side backpressure
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // call at a falling edge; leaves s_tvalid high
  task automatic send_request(input vec_req_t q, input logic fixed, input vec_res_t fx);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= {q.s, q.b, q.a};
    s_tuser   <= q.func;
    row_fixed <= fixed;
    row_res   <= fx;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid  <= 1'b0;
    row_fixed <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ACTIVE_DIMS) dims_q = val[1:0];
    else tol_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 4))
          0: return SMAX;
          1: return SMIN;
          2: return 32'd0;
          3: return 32'd1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 21)
                                            : -$urandom_range(0, 1 << 21);
    endcase
  endfunction

  function automatic vec_req_t rand_request();
    vec_req_t q;
    q.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                          : 4'($urandom_range(0, 11));
    for (int i = 0; i < 3; i++) begin
      q.a[i] = rand_comp();
      q.b[i] = rand_comp();
    end
    q.s = rand_comp();
    if (q.func == F_EQUAL && $urandom_range(0, 1)) q.b = q.a;
    if ((q.func == F_NORM || q.func == F_IS_ZERO) && $urandom_range(0, 5) == 0) q.a = '0;
    if (q.func == F_DIV && $urandom_range(0, 7) == 0) q.s = '0;
    return q;
  endfunction

  function automatic vec_row_t mk_row(input func_t f, input logic [95:0] a,
                                      input logic [95:0] b, input logic [31:0] s,
                                      input logic fixed, input logic [95:0] r,
                                      input logic [31:0] sc, input logic truth,
                                      input status_t st);
    vec_row_t row;
    row.req = {f, a, b, s};
    row.fixed = fixed;
    row.res = {r, sc, truth, st};
    return row;
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] M1  = 32'hFFFF_FFFF;

  initial begin
    logic [30:0] tol_set[6];
    logic [1:0]  dim_set[6];
    vec_row_t    row;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    row_fixed = 1'b0;
    row_res = '0;
    dims_q = 2'd3;
    tol_q = '0;
    errors = 0;
    n_req = 0;
    n_res = 0;
    gap_max = 15;
    rx_max = 15;
    idle_cycles = 0;
    status_seen = '{default: 0};

    // vectors are {z, y, x}
    rows = {rows, mk_row(F_ADD, {32'd1, SMIN, SMAX}, {32'd2, SMIN, SMAX}, 0, 1,
                         {32'd3, SMIN, SMAX}, 0, 0, ST_SAT)};
    rows = {rows, mk_row(F_SUB, {32'd0, 32'd1, 32'd0}, {32'd0, 32'd0, SMIN}, 0, 1,
                         {32'd0, 32'd1, SMAX}, 0, 0, ST_SAT)};
    rows = {rows, mk_row(F_SCALE, {2 * ONE, -ONE, ONE}, '0, 3 * ONE, 1,
                         {6 * ONE, -3 * ONE, 3 * ONE}, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_SCALE, {SMIN, SMAX, SMIN}, '0, SMIN, 0, '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_DIV, {ONE, SMAX, SMIN}, '0, 0, 1, '0, 0, 0, ST_DIVZ)};
    rows = {rows, mk_row(F_DIV, {ONE, SMAX, SMIN}, '0, M1, 0, '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_NEG, {32'd0, 32'd5, SMIN}, '0, 0, 1,
                         {32'd0, -32'd5, SMAX}, 0, 0, ST_SAT)};
    rows = {rows, mk_row(F_DOT, {SMIN, SMIN, SMIN}, {SMIN, SMIN, SMIN}, 0, 0,
                         '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_DOT, {SMAX, M1, SMIN}, {SMIN, M1, SMAX}, 0, 0,
                         '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_CROSS, {32'd0, 32'd0, ONE}, {32'd0, ONE, 32'd0}, 0, 1,
                         {ONE, 32'd0, 32'd0}, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_CROSS, {SMIN, SMAX, SMIN}, {SMAX, SMIN, SMIN}, 0, 0,
                         '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_LENGTH, {32'd0, 4 * ONE, 3 * ONE}, '0, 0, 1,
                         '0, 5 * ONE, 0, ST_OK)};
    rows = {rows, mk_row(F_LENGTH, {SMIN, SMIN, SMIN}, '0, 0, 1, '0, SMAX, 0, ST_SAT)};
    rows = {rows, mk_row(F_DIST, {SMAX, SMAX, SMAX}, {SMIN, SMIN, SMIN}, 0, 0,
                         '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_NORM, '0, '0, 0, 1, '0, 0, 0, ST_DIVZ)};
    rows = {rows, mk_row(F_NORM, {32'd0, 4 * ONE, 3 * ONE}, '0, 0, 0, '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_NORM, {32'd0, 32'd0, 32'd1}, '0, 0, 0, '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_IS_ZERO, '0, '0, 0, 1, '0, 0, 1, ST_OK)};
    rows = {rows, mk_row(F_IS_ZERO, {32'd0, 32'd0, 32'd1}, '0, 0, 1, '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_IS_ZERO, {SMIN, 32'd0, 32'd0}, '0, 0, 0, '0, 0, 0, ST_OK)};
    rows = {rows, mk_row(F_EQUAL, {SMIN, M1, SMAX}, {SMIN, M1, SMAX}, 0, 1,
                         '0, 0, 1, ST_OK)};
    rows = {rows, mk_row(F_EQUAL, {SMIN, M1, SMAX}, {SMIN, 32'd0, SMAX}, 0, 1,
                         '0, 0, 0, ST_OK)};
    for (int f = 12; f < 16; f++) begin
      row = mk_row(F_ADD, {SMAX, M1, ONE}, {SMIN, ONE, M1}, M1, 1, '0, 0, 0, ST_OK);
      row.req.func = 4'(f);
      rows = {rows, row};
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_request(rows[i].req, rows[i].fixed, rows[i].res);
    drain();

    dim_set = '{2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd3};
    tol_set = '{31'd0, 31'($urandom_range(0, 1 << 21)), 31'h7FFF_FFFF, 31'(ONE),
                31'd0, 31'($urandom())};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ACTIVE_DIMS, {29'd0, dim_set[ph]});
      write_reg(REG_ZERO_TOL, tol_set[ph]);
      gap_max = (ph % 3 == 1) ? 0 : 15;
      rx_max = (ph % 3 == 2) ? 0 : 15;
      @(negedge clk);
      for (int i = 0; i < 140; i++) send_request(rand_request(), 1'b0, '0);
      // sender holds off until every outstanding result is back
      drain();
    end

    repeat (100) @(negedge clk);
    $display("Covered %0d requests and %0d results over six dimension/tolerance settings.",
             n_req, n_res);
    $display("Status counts ok/divz/cross/sat: %0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### vector3_arithmetic_unit.f
+incdir+rtl
rtl/v3au_pkg.sv
rtl/v3au_lane.sv
rtl/v3au_merge.sv
rtl/v3au_sqrt.sv
rtl/v3au_div.sv
rtl/vector3_arithmetic_unit.sv
test/vector3_arithmetic_unit_tb.sv
